[rtl/pwmpdc_pkg.sv]
package pwmpdc_pkg;

    localparam int CLOCK_W     = 27;
    localparam int DUTY_W      = 7;
    localparam int CNT_W       = $clog2(CLOCK_W + 1);
    localparam int DUTY_SCALE  = 100;
    localparam int CLOCK_RESET = 8000000;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_FALL   = 2'd2
    } t_phase;

endpackage

[rtl/pwm_period_duty_capture.sv]
// first and second rising-edge captures: result registered in the cycle after the transfer
// falling-edge capture: with a zero period the result is registered directly, else it is
// set by the shared restoring divider (one quotient bit a cycle, 27 for frequency, 7 for
// duty unless high >= period); one capture at a time: none is taken while the divider runs
// synchronous active-low reset: phase to first rising edge, captures and period to zero,
// clock_hz to 8000000, no result pending
module pwm_period_duty_capture
    import pwmpdc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COUNT_WIDTH-1:0] i_capture_count,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_arm_falling_edge,
    output logic                   o_measurement_done,
    output logic [COUNT_WIDTH-1:0] o_period_ticks,
    output logic [COUNT_WIDTH-1:0] o_high_ticks,
    output logic [CLOCK_W-1:0]     o_frequency_hz,
    output logic [DUTY_W-1:0]      o_duty_percent,
    output logic                   o_zero_period,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CLOCK_W-1:0]     i_cfg_data
);

    localparam int PW = COUNT_WIDTH + DUTY_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREQ,
        S_DUTY,
        S_FIN
    } t_state;

    t_state                 r_state;
    t_phase                 r_phase;
    logic [COUNT_WIDTH-1:0] r_first;
    logic [COUNT_WIDTH-1:0] r_second;
    logic [COUNT_WIDTH-1:0] r_period;
    logic [COUNT_WIDTH-1:0] r_high;
    logic [CLOCK_W-1:0]     r_clock_hz;
    logic [CLOCK_W-1:0]     r_dvd;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic [CLOCK_W-1:0]     r_freq;
    logic [DUTY_W-1:0]      r_duty;

    logic                   r_o_valid;
    logic                   r_o_arm;
    logic                   r_o_done;
    logic [COUNT_WIDTH-1:0] r_o_per;
    logic [COUNT_WIDTH-1:0] r_o_high;
    logic [CLOCK_W-1:0]     r_o_freq;
    logic [DUTY_W-1:0]      r_o_duty;
    logic                   r_o_zero;

    logic                   out_free;
    logic                   take;
    logic [COUNT_WIDTH-1:0] diff_period;
    logic [COUNT_WIDTH-1:0] diff_high;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic [COUNT_WIDTH:0]   rem_sub;
    logic                   rem_ge;
    logic [COUNT_WIDTH-1:0] n_rem;
    logic [CLOCK_W-1:0]     n_dvd;
    logic [PW-1:0]          prod;

    assign out_free    = !r_o_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE) || !out_free;
    assign take        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign diff_period = i_capture_count - r_first;
    assign diff_high   = i_capture_count - r_second;

    // shared restoring divide step
    assign rem_sh  = {r_rem, r_dvd[CLOCK_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_period};
    assign rem_sub = rem_sh - {1'b0, r_period};
    assign n_rem   = rem_ge ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
    assign n_dvd   = {r_dvd[CLOCK_W-2:0], rem_ge};

    assign prod = {{DUTY_W{1'b0}}, r_high} * PW'(DUTY_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_FIRST;
            r_first    <= '0;
            r_second   <= '0;
            r_period   <= '0;
            r_high     <= '0;
            r_clock_hz <= CLOCK_W'(CLOCK_RESET);
            r_cnt      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clock_hz <= i_cfg_data;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_o_arm  <= 1'b0;
                        r_o_done <= 1'b0;
                        r_o_per  <= '0;
                        r_o_high <= '0;
                        r_o_freq <= '0;
                        r_o_duty <= '0;
                        r_o_zero <= 1'b0;
                        priority case (r_phase)
                            PH_SECOND: begin
                                r_second  <= i_capture_count;
                                r_period  <= diff_period;
                                r_o_per   <= diff_period;
                                r_o_arm   <= 1'b1;
                                r_o_valid <= 1'b1;
                                r_phase   <= PH_FALL;
                            end
                            PH_FALL: begin
                                r_high  <= diff_high;
                                r_phase <= PH_FIRST;
                                if (r_period == '0) begin
                                    r_o_done  <= 1'b1;
                                    r_o_zero  <= 1'b1;
                                    r_o_high  <= diff_high;
                                    r_o_valid <= 1'b1;
                                end else begin
                                    r_dvd   <= r_clock_hz;
                                    r_rem   <= '0;
                                    r_cnt   <= CNT_W'(CLOCK_W);
                                    r_state <= S_FREQ;
                                end
                            end
                            default: begin
                                r_first   <= i_capture_count;
                                r_phase   <= PH_SECOND;
                                r_o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FREQ: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_freq <= n_dvd;
                        if (r_high >= r_period) begin
                            r_duty  <= DUTY_W'(DUTY_SCALE);
                            r_state <= S_FIN;
                        end else begin
                            r_dvd   <= {prod[DUTY_W-1:0], {(CLOCK_W-DUTY_W){1'b0}}};
                            r_rem   <= prod[PW-1:DUTY_W];
                            r_cnt   <= CNT_W'(DUTY_W);
                            r_state <= S_DUTY;
                        end
                    end
                end
                S_DUTY: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_duty  <= n_dvd[DUTY_W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_arm   <= 1'b0;
                        r_o_done  <= 1'b1;
                        r_o_per   <= r_period;
                        r_o_high  <= r_high;
                        r_o_freq  <= r_freq;
                        r_o_duty  <= r_duty;
                        r_o_zero  <= 1'b0;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_valid            = r_o_valid;
    assign o_arm_falling_edge = r_o_arm;
    assign o_measurement_done = r_o_done;
    assign o_period_ticks     = r_o_per;
    assign o_high_ticks       = r_o_high;
    assign o_frequency_hz     = r_o_freq;
    assign o_duty_percent     = r_o_duty;
    assign o_zero_period      = r_o_zero;

endmodule

[rtl/pwmpdc_chk.sv]
module pwmpdc_chk
    import pwmpdc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_measurement_done,
    input logic [COUNT_WIDTH-1:0] o_period_ticks,
    input logic [COUNT_WIDTH-1:0] o_high_ticks,
    input logic [CLOCK_W-1:0]     o_frequency_hz,
    input logic [DUTY_W-1:0]      o_duty_percent,
    input logic                   o_zero_period
);

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_duty_percent <= DUTY_W'(DUTY_SCALE))
        else $error("duty above full scale");

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_period |-> o_measurement_done && o_frequency_hz == '0
            && o_duty_percent == '0 && o_period_ticks == '0)
        else $error("zero period result inconsistent");

    a_arm_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_measurement_done |-> o_high_ticks == '0 && o_frequency_hz == '0
            && o_duty_percent == '0 && !o_zero_period)
        else $error("partial result carries measurement fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_period_ticks)
            && $stable(o_frequency_hz) && $stable(o_duty_percent))
        else $error("stalled result changed");

endmodule

bind pwm_period_duty_capture pwmpdc_chk #(.COUNT_WIDTH(COUNT_WIDTH)) u_pwmpdc_chk (.*);

[tb/tb_pwm_period_duty_capture.sv]
module tb_pwm_period_duty_capture;
    import pwmpdc_pkg::*;

    localparam int CW              = 16;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int IDLE_PCT        = 38;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int SETTLE_CYCLES   = 40;
    localparam int MAX_REPORTS     = 100;

    typedef struct packed {
        logic               arm_falling_edge;
        logic               measurement_done;
        logic [CW-1:0]      period_ticks;
        logic [CW-1:0]      high_ticks;
        logic [CLOCK_W-1:0] frequency_hz;
        logic [DUTY_W-1:0]  duty_percent;
        logic               zero_period;
    } t_measurement;

    class measurement_scoreboard;
        t_phase             phase;
        logic [CW-1:0]      first_capture;
        logic [CW-1:0]      second_capture;
        logic [CW-1:0]      held_period;
        logic [CLOCK_W-1:0] clock_hz;
        t_measurement       expected_measurements[$];
        int                 errors;

        function new();
            phase          = PH_FIRST;
            first_capture  = '0;
            second_capture = '0;
            held_period    = '0;
            clock_hz       = CLOCK_W'(CLOCK_RESET);
            errors         = 0;
        endfunction

        function void set_clock(logic [CLOCK_W-1:0] hz);
            clock_hz = hz;
        endfunction

        // advance the capture phase and queue the measurement it yields
        function void note_capture(logic [CW-1:0] cap);
            t_measurement m;
            logic [31:0]  duty;
            m = '0;
            case (phase)
                PH_SECOND: begin
                    second_capture     = cap;
                    held_period        = cap - first_capture;
                    m.period_ticks     = held_period;
                    m.arm_falling_edge = 1'b1;
                    phase              = PH_FALL;
                end
                PH_FALL: begin
                    m.high_ticks       = cap - second_capture;
                    m.period_ticks     = held_period;
                    m.measurement_done = 1'b1;
                    if (held_period == '0) begin
                        m.zero_period = 1'b1;
                    end else begin
                        m.frequency_hz = clock_hz / held_period;
                        duty = (32'(m.high_ticks) * DUTY_SCALE) / held_period;
                        m.duty_percent = (duty > DUTY_SCALE) ? DUTY_W'(DUTY_SCALE)
                                                             : duty[DUTY_W-1:0];
                    end
                    phase = PH_FIRST;
                end
                default: begin
                    first_capture = cap;
                    phase         = PH_SECOND;
                end
            endcase
            expected_measurements.push_back(m);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            if (errors < MAX_REPORTS)
                $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_measurement(t_measurement got);
            t_measurement want;
            if (expected_measurements.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
                return;
            end
            want = expected_measurements.pop_front();
            if (got.arm_falling_edge !== want.arm_falling_edge)
                report_mismatch("arm_falling_edge", got.arm_falling_edge,
                                want.arm_falling_edge);
            if (got.measurement_done !== want.measurement_done)
                report_mismatch("measurement_done", got.measurement_done,
                                want.measurement_done);
            if (got.period_ticks !== want.period_ticks)
                report_mismatch("period_ticks", got.period_ticks, want.period_ticks);
            if (got.high_ticks !== want.high_ticks)
                report_mismatch("high_ticks", got.high_ticks, want.high_ticks);
            if (got.frequency_hz !== want.frequency_hz)
                report_mismatch("frequency_hz", got.frequency_hz, want.frequency_hz);
            if (got.duty_percent !== want.duty_percent)
                report_mismatch("duty_percent", got.duty_percent, want.duty_percent);
            if (got.zero_period !== want.zero_period)
                report_mismatch("zero_period", got.zero_period, want.zero_period);
        endtask
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic [CW-1:0]      i_capture_count = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic               o_arm_falling_edge;
    logic               o_measurement_done;
    logic [CW-1:0]      o_period_ticks;
    logic [CW-1:0]      o_high_ticks;
    logic [CLOCK_W-1:0] o_frequency_hz;
    logic [DUTY_W-1:0]  o_duty_percent;
    logic               o_zero_period;
    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [CLOCK_W-1:0] i_cfg_data      = '0;

    logic                  calm = 1'b0;
    int                    cycle_count = 0;
    t_measurement          observed;
    measurement_scoreboard meas_sb;

    pwm_period_duty_capture #(
        .COUNT_WIDTH(CW)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_capture_count   (i_capture_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_arm_falling_edge(o_arm_falling_edge),
        .o_measurement_done(o_measurement_done),
        .o_period_ticks    (o_period_ticks),
        .o_high_ticks      (o_high_ticks),
        .o_frequency_hz    (o_frequency_hz),
        .o_duty_percent    (o_duty_percent),
        .o_zero_period     (o_zero_period),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    assign observed = {o_arm_falling_edge, o_measurement_done, o_period_ticks, o_high_ticks,
                       o_frequency_hz, o_duty_percent, o_zero_period};

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            meas_sb.check_measurement(observed);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_pwm_period_duty_capture: FAIL");
            $finish;
        end
    end

    task automatic send_capture(input logic [CW-1:0] cap);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_capture_count <= cap;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        meas_sb.note_capture(cap);
        @(negedge i_clk);
    endtask

    task automatic write_clock(input logic [CLOCK_W-1:0] hz);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        meas_sb.set_clock(hz);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (meas_sb.expected_measurements.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // mostly rising, rising, falling sequences; some raw captures as noise
    task automatic send_pwm_cycle(output int n);
        logic [CW-1:0] base;
        logic [CW-1:0] period;
        logic [CW-1:0] high;
        int            pick;
        n    = 0;
        pick = $urandom_range(9);
        if (pick >= 8) begin
            repeat ($urandom_range(3, 1)) begin
                send_capture(CW'($urandom));
                n++;
            end
            return;
        end
        while (meas_sb.phase != PH_FIRST) begin
            send_capture(CW'($urandom));
            n++;
        end
        base = CW'($urandom);
        pick = $urandom_range(9);
        if (pick <= 3)
            period = CW'($urandom_range(255, 1));
        else if (pick <= 6)
            period = CW'($urandom);
        else if (pick == 7)
            period = '0;
        else
            period = {CW{1'b1}} >> $urandom_range(CW - 1);
        pick = $urandom_range(9);
        if (pick <= 6)
            high = CW'($urandom_range(period));
        else if (pick == 7)
            high = period;
        else
            high = CW'($urandom);
        send_capture(base);
        send_capture(base + period);
        send_capture(base + period + high);
        n += 3;
    endtask

    logic [CW-1:0] directed_captures [24] = '{
        16'd0,     16'd65535, 16'd0,
        16'd100,   16'd100,   16'd150,
        16'd65535, 16'd0,     16'd65535,
        16'd1000,  16'd2000,  16'd1500,
        16'd0,     16'd1,     16'd1,
        16'd65000, 16'd500,   16'd1000,
        16'd10,    16'd20,    16'd30,
        16'd5,     16'd5,     16'd5
    };

    logic [CLOCK_W-1:0] clock_settings [6] = '{
        CLOCK_W'(8000000), CLOCK_W'(1), CLOCK_W'(100000000),
        CLOCK_W'(0), {CLOCK_W{1'b1}}, CLOCK_W'(8000000)
    };

    initial begin
        int sent;
        int n;
        meas_sb           = new();
        clock_settings[5] = CLOCK_W'($urandom_range(100000000, 1));
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_captures[k])
            send_capture(directed_captures[k]);

        foreach (clock_settings[p]) begin
            drain();
            write_clock(clock_settings[p]);
            calm = (p == 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                send_pwm_cycle(n);
                sent += n;
            end
        end
        drain();

        if (meas_sb.errors == 0)
            $display("tb_pwm_period_duty_capture: PASS");
        else
            $display("tb_pwm_period_duty_capture: FAIL");
        $finish;
    end

endmodule
